FILE: sv/rar_pkg.sv
// Package for the rational arithmetic reduce block.
// Holds operation codes and the result widths; no dependencies.
package rar_pkg;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;
endpackage

FILE: sv/rar_front.sv
// Front end: accepts a beat, forms the raw numerator and denominator.
// Depends on rar_pkg. Three multipliers form all products together in phase 1.
module rar_front import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [1:0] i_action,
    input  logic signed [15:0] i_a_numerator,
    input  logic signed [15:0] i_a_denominator,
    input  logic signed [15:0] i_b_numerator,
    input  logic signed [15:0] i_b_denominator,
    output logic o_valid,
    input  logic i_ready,
    output logic o_num_neg,
    output logic [2*OPERAND_WIDTH:0] o_num_mag,
    output logic o_den_neg,
    output logic [2*OPERAND_WIDTH-1:0] o_den_mag
);
    localparam int W = OPERAND_WIDTH;
    localparam int PW = 2 * W;

    logic [1:0] r_phase;
    logic [1:0] r_act;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic r_ann, r_adn, r_bnn, r_bdn;
    logic [PW-1:0] r_p0, r_p1;
    logic r_s0, r_s1;
    logic [PW-1:0] r_p2;
    logic r_s2;
    logic r_num_neg, r_den_neg;
    logic [PW:0] r_num_mag;
    logic [PW-1:0] r_den_mag;

    function automatic logic [W:0] smag(input logic [15:0] raw);
        logic [W-1:0] v;
        logic [W-1:0] m;
        v = W'({{(W > 16 ? W - 16 : 1){raw[15]}}, raw});
        m = v[W-1] ? W'(~v + W'(1)) : v;
        return {v[W-1], m};
    endfunction

    logic [W:0] n_an, n_ad, n_bn, n_bd;
    assign n_an = smag(i_a_numerator);
    assign n_ad = smag(i_a_denominator);
    assign n_bn = smag(i_b_numerator);
    assign n_bd = smag(i_b_denominator);

    // Phase 1 forms an*bd and ad*bn (or an*bn for mul) and the denominator product.
    logic [W-1:0] m0x, m0y, m1x, m1y;
    logic s0x, s0y, s1x, s1y;
    logic [PW-1:0] m0, m1;
    always_comb begin
        m0x = r_an; m0y = r_bd; s0x = r_ann; s0y = r_bdn;
        m1x = r_ad; m1y = r_bn; s1x = r_adn; s1y = r_bnn;
        if (r_act == OP_MUL) begin
            m0y = r_bn; s0y = r_bnn;
            m1y = r_bd; s1y = r_bdn;
        end
    end
    assign m0 = PW'(m0x) * PW'(m0y);
    assign m1 = PW'(m1x) * PW'(m1y);
    logic ms0, ms1;
    assign ms0 = (s0x ^ s0y) && (m0 != '0);
    assign ms1 = (s1x ^ s1y) && (m1 != '0);

    logic [PW-1:0] den2;
    assign den2 = PW'(r_ad) * PW'(r_bd);

    logic s1e;
    logic [PW:0] sa, sb;
    logic sum_neg;
    logic [PW:0] sum_mag;
    always_comb begin
        s1e = (r_act == OP_SUB) ? (!r_s1 && r_p1 != '0) : r_s1;
        sa = {1'b0, r_p0};
        sb = {1'b0, r_p1};
        if (r_s0 == s1e) begin
            sum_mag = sa + sb; sum_neg = r_s0;
        end else if (sa >= sb) begin
            sum_mag = sa - sb; sum_neg = r_s0;
        end else begin
            sum_mag = sb - sa; sum_neg = s1e;
        end
        if (sum_mag == '0) sum_neg = 1'b0;
    end

    assign o_ready = (r_phase == 2'd0);
    assign o_valid = (r_phase == 2'd3);
    assign o_num_neg = r_num_neg;
    assign o_num_mag = r_num_mag;
    assign o_den_neg = r_den_neg;
    assign o_den_mag = r_den_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else begin
            case (r_phase)
                2'd0: if (i_valid) r_phase <= 2'd1;
                2'd1: r_phase <= 2'd2;
                2'd2: r_phase <= 2'd3;
                2'd3: if (i_ready) r_phase <= 2'd0;
                default: r_phase <= 2'd0;
            endcase
        end
        if (r_phase == 2'd0 && i_valid) begin
            r_act <= i_action;
            {r_ann, r_an} <= n_an;
            {r_adn, r_ad} <= n_ad;
            {r_bnn, r_bn} <= n_bn;
            {r_bdn, r_bd} <= n_bd;
        end
        if (r_phase == 2'd1) begin
            r_p0 <= m0; r_s0 <= ms0;
            r_p1 <= m1; r_s1 <= ms1;
            r_p2 <= den2;
            r_s2 <= (r_adn ^ r_bdn) && (den2 != '0);
        end
        if (r_phase == 2'd2) begin
            case (r_act)
                OP_ADD, OP_SUB: begin
                    r_num_mag <= sum_mag; r_num_neg <= sum_neg;
                    r_den_mag <= r_p2;    r_den_neg <= r_s2;
                end
                OP_MUL: begin
                    r_num_mag <= {1'b0, r_p0}; r_num_neg <= r_s0;
                    r_den_mag <= r_p2;         r_den_neg <= r_s2;
                end
                default: begin
                    r_num_mag <= {1'b0, r_p0}; r_num_neg <= r_s0;
                    r_den_mag <= r_p1;         r_den_neg <= r_s1;
                end
            endcase
        end
    end
endmodule

FILE: sv/rar_queue.sv
// Two-entry queue between front and back for the raw fraction.
// No dependencies beyond its parameter.
module rar_queue #(
    parameter int DW = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [DW-1:0] i_data,
    output logic o_valid,
    input  logic i_ready,
    output logic [DW-1:0] o_data
);
    logic [DW-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

FILE: sv/rar_back.sv
// Back end: Euclid gcd by iterated restoring division, then two exact divisions.
// Depends on rar_pkg. One shared bit-serial divider does all the work.
module rar_back import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_num_neg,
    input  logic [2*OPERAND_WIDTH:0] i_num_mag,
    input  logic i_den_neg,
    input  logic [2*OPERAND_WIDTH-1:0] i_den_mag,
    output logic o_valid,
    input  logic i_ready,
    output logic signed [NUM_OUT_W-1:0] o_result_numerator,
    output logic signed [DEN_OUT_W-1:0] o_result_denominator,
    output logic o_zero_gcd_error
);
    localparam int MW = 2 * OPERAND_WIDTH + 1;
    localparam int CW = $clog2(MW + 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_DN   = 3'd2;
    localparam logic [2:0] S_DD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_st;
    logic r_nn, r_dn;
    logic [MW-1:0] r_nm, r_dm;
    logic [MW-1:0] r_x, r_y;
    logic [MW-1:0] r_q, r_rem, r_dvd, r_dvs;
    logic [CW-1:0] r_bit;
    logic r_busy;
    logic [MW-1:0] r_g;
    logic r_err;
    logic [NUM_OUT_W-1:0] r_on;
    logic [DEN_OUT_W-1:0] r_od;

    logic [MW:0] trial;
    logic [MW-1:0] n_rem;
    logic n_qb;
    always_comb begin
        trial = {r_rem, r_dvd[MW-1]} - {1'b0, r_dvs};
        n_qb = !trial[MW];
        n_rem = n_qb ? trial[MW-1:0] : {r_rem[MW-2:0], r_dvd[MW-1]};
    end
    logic last;
    assign last = (r_bit == CW'(1));

    function automatic logic [63:0] tw(input logic neg, input logic [MW-1:0] m);
        logic [63:0] u;
        u = 64'(m);
        return neg ? (64'd0 - u) : u;
    endfunction
    logic [63:0] twn, twd;
    assign twn = tw(r_nn, r_q);
    assign twd = tw(r_dn, r_q);

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_result_numerator = r_on;
    assign o_result_denominator = r_od;
    assign o_zero_gcd_error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_busy <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_nn <= i_num_neg; r_dn <= i_den_neg;
                    r_nm <= i_num_mag; r_dm <= MW'(i_den_mag);
                    r_x <= i_num_mag;  r_y <= MW'(i_den_mag);
                    r_busy <= 1'b0;
                    r_st <= S_GCD;
                end
                S_GCD: begin
                    if (!r_busy) begin
                        if (r_y == '0) begin
                            r_g <= r_x;
                            if (r_x == '0) begin
                                r_err <= 1'b1; r_on <= '0; r_od <= '0;
                                r_st <= S_OUT;
                            end else begin
                                r_err <= 1'b0;
                                r_dvd <= r_nm; r_dvs <= r_x;
                                r_rem <= '0; r_bit <= CW'(MW); r_busy <= 1'b1;
                                r_st <= S_DN;
                            end
                        end else begin
                            r_dvd <= r_x; r_dvs <= r_y;
                            r_rem <= '0; r_bit <= CW'(MW); r_busy <= 1'b1;
                        end
                    end else begin
                        r_rem <= n_rem; r_dvd <= {r_dvd[MW-2:0], 1'b0};
                        r_bit <= r_bit - CW'(1);
                        if (last) begin
                            r_x <= r_y; r_y <= n_rem; r_busy <= 1'b0;
                        end
                    end
                end
                S_DN, S_DD: begin
                    if (r_busy) begin
                        r_rem <= n_rem; r_dvd <= {r_dvd[MW-2:0], 1'b0};
                        r_q <= {r_q[MW-2:0], n_qb};
                        r_bit <= r_bit - CW'(1);
                        if (last) r_busy <= 1'b0;
                    end else if (r_st == S_DN) begin
                        r_on <= twn[NUM_OUT_W-1:0];
                        r_dvd <= r_dm; r_dvs <= r_g;
                        r_rem <= '0; r_bit <= CW'(MW); r_busy <= 1'b1;
                        r_st <= S_DD;
                    end else begin
                        r_od <= twd[DEN_OUT_W-1:0];
                        r_st <= S_OUT;
                    end
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/rational_arith_reduce.sv
// Rational arithmetic on two signed fractions with gcd reduction.
// Beats enter on the i_valid/o_ready channel with an operation code and two
// fractions; the reduced result leaves on o_valid/i_ready.
// The front end forms the raw numerator and denominator with three
// multipliers, one beat at a time. A two-entry queue passes the raw
// fraction to the back end, which runs Euclid's algorithm with a bit-serial
// restoring divider, then divides both parts by the gcd with the same
// divider. The back end finishes one fraction before it takes the next.
// Both raw parts zero gives 0/0 with o_zero_gcd_error set.
// Reset clears all handshake state; results held while the receiver stalls
// stay valid and unchanged, and the front end keeps taking beats until the
// queue fills.
// Depends on rar_pkg, rar_front, rar_queue and rar_back.
module rational_arith_reduce import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [1:0] i_action,
    input  logic signed [15:0] i_a_numerator,
    input  logic signed [15:0] i_a_denominator,
    input  logic signed [15:0] i_b_numerator,
    input  logic signed [15:0] i_b_denominator,
    output logic o_valid,
    input  logic i_ready,
    output logic signed [NUM_OUT_W-1:0] o_result_numerator,
    output logic signed [DEN_OUT_W-1:0] o_result_denominator,
    output logic o_zero_gcd_error
);
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int QW = 2 * PW + 3;

    logic f_valid, f_ready, b_valid, b_ready;
    logic f_nn, f_dn;
    logic [PW:0] f_nm;
    logic [PW-1:0] f_dm;
    logic [QW-1:0] q_out;

    rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action),
        .i_a_numerator(i_a_numerator), .i_a_denominator(i_a_denominator),
        .i_b_numerator(i_b_numerator), .i_b_denominator(i_b_denominator),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_num_neg(f_nn), .o_num_mag(f_nm), .o_den_neg(f_dn), .o_den_mag(f_dm)
    );

    rar_queue #(.DW(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready),
        .i_data({f_nn, f_nm, f_dn, f_dm}),
        .o_valid(b_valid), .i_ready(b_ready),
        .o_data(q_out)
    );

    rar_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready),
        .i_num_neg(q_out[QW-1]), .i_num_mag(q_out[QW-2:PW+1]),
        .i_den_neg(q_out[PW]), .i_den_mag(q_out[PW-1:0]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_numerator(o_result_numerator),
        .o_result_denominator(o_result_denominator),
        .o_zero_gcd_error(o_zero_gcd_error)
    );
endmodule

FILE: sim/tb_rational_arith_reduce.sv
// Self-checking testbench for rational_arith_reduce: drives fraction beats with
// random idling and stalls, predicts each reduced result, and compares in order.
// Depends on rar_pkg and the rational_arith_reduce RTL.
`timescale 1ns / 1ps

module tb_rational_arith_reduce;
    import rar_pkg::*;

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] num;
        logic signed [DEN_OUT_W-1:0] den;
        logic                        err;
    } t_fraction;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_action = OP_ADD;
    logic signed [15:0] i_a_numerator = '0;
    logic signed [15:0] i_a_denominator = '0;
    logic signed [15:0] i_b_numerator = '0;
    logic signed [15:0] i_b_denominator = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [NUM_OUT_W-1:0] o_result_numerator;
    logic signed [DEN_OUT_W-1:0] o_result_denominator;
    logic o_zero_gcd_error;

    t_fraction expected_q[$];
    int  fail_count = 0;
    int  stall_left = 0;
    bit  idle_enable = 1'b1;
    bit  hold_off = 1'b0;

    rational_arith_reduce dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_fraction reduce_fraction(logic [1:0] op, logic signed [15:0] an,
                                                  logic signed [15:0] ad,
                                                  logic signed [15:0] bn,
                                                  logic signed [15:0] bd);
        longint n, d, x, y, t;
        t_fraction r;
        case (op)
            OP_ADD: begin
                n = longint'(an) * bd + longint'(ad) * bn;
                d = longint'(ad) * bd;
            end
            OP_SUB: begin
                n = longint'(an) * bd - longint'(ad) * bn;
                d = longint'(ad) * bd;
            end
            OP_MUL: begin
                n = longint'(an) * bn;
                d = longint'(ad) * bd;
            end
            default: begin
                n = longint'(an) * bd;
                d = longint'(ad) * bn;
            end
        endcase
        x = (n < 0) ? -n : n;
        y = (d < 0) ? -d : d;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x == 0) begin
            r = '{num: '0, den: '0, err: 1'b1};
        end else begin
            r.num = NUM_OUT_W'(n / x);
            r.den = DEN_OUT_W'(d / x);
            r.err = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    task automatic idle_gap();
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic send_beat(logic [1:0] op, logic signed [15:0] an, logic signed [15:0] ad,
                             logic signed [15:0] bn, logic signed [15:0] bd);
        idle_gap();
        i_action <= op;
        i_a_numerator <= an;
        i_a_denominator <= ad;
        i_b_numerator <= bn;
        i_b_denominator <= bd;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(reduce_fraction(op, an, ad, bn, bd));
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(signed'($urandom_range(0, 8)) - 4);
            3: return 16'(signed'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stall bursts, or a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            stall_left = $urandom_range(0, 11);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat", o_result_numerator, 0);
            end else begin
                want = expected_q.pop_front();
                if (o_result_numerator !== want.num)
                    report_mismatch("numerator", o_result_numerator, want.num);
                if (o_result_denominator !== want.den)
                    report_mismatch("denominator", o_result_denominator, want.den);
                if (o_zero_gcd_error !== want.err)
                    report_mismatch("error flag", o_zero_gcd_error, want.err);
            end
        end
    end

    task automatic test_directed();
        logic [1:0] op;
        for (int k = 0; k < 4; k++) begin
            op = 2'(k);
            send_beat(op, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
            send_beat(op, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
            send_beat(op, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
            send_beat(op, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        end
        send_beat(OP_MUL, 16'sd5, 16'sd0, 16'sd3, 16'sd7);
        send_beat(OP_MUL, -16'sd5, 16'sd0, 16'sd3, 16'sd7);
        send_beat(OP_ADD, 16'sd0, 16'sd4, 16'sd0, -16'sd9);
        send_beat(OP_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
        send_beat(OP_DIV, 16'sd6, -16'sd4, 16'sd0, 16'sd9);
        send_beat(OP_DIV, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            send_beat(2'($urandom), rand_operand(), rand_operand(), rand_operand(),
                      rand_operand());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(8);
            repeat (3000) @(posedge i_clk);
        join_any
        hold_off = 1'b0;
        wait fork;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(900);
        idle_enable = 1'b0;
        test_random(170);
        i_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
